// File: rtl/core/wrf_pkg.sv
// Package with shared constants and word types of the waypoint route follower.
package wrf_pkg;

  localparam int ROUTE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(ROUTE_DEPTH);
  localparam int LEN_W       = $clog2(ROUTE_DEPTH + 1);
  localparam int POS_W       = 24;
  localparam int TIDX_W      = 7;
  localparam int CFG_W       = 16;
  localparam int WP_W        = 2 * POS_W;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_SETPOS = 2'd2;

  localparam logic CFG_SPEED  = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  localparam logic [CFG_W-1:0] SPEED_RESET  = 16'd10240;
  localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd768;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [POS_W-1:0] coord_x;
    logic signed [POS_W-1:0] coord_y;
    logic [15:0]             step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TIDX_W-1:0]       target_index;
    logic                    route_done;
    logic                    rejected;
  } out_word_t;

endpackage

// File: rtl/core/wrf_stream_if.sv
// Valid/ready stream interfaces for the input and result words.
interface wrf_in_if;
  import wrf_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wrf_out_if;
  import wrf_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/wrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/waypoint_route_follower_core.sv
// Top level of the waypoint route follower: sequencer around one multiplier.
//
// The block takes one word at a time on in_ch and returns exactly one result
// word on out_ch for each. An append (mode 0) writes the next free entry of
// the route table, or flags the word as rejected when the table is full. A
// set-position word (mode 2) loads the vehicle position. A step word (mode 1)
// reads the current waypoint, squares the offsets, and either advances to
// the next waypoint or moves the vehicle toward it at the set speed.
// Appends, position loads and ignored steps pass through the execute state to
// the result register. A moving step runs a 25-step square-root recurrence
// and two 16-step restoring divisions, all driven by the same sequencer,
// with one 25x32 multiplier shared for the squares, the speed times time
// product and the per-axis scaling. An arrival step ends at the radius
// comparison, and a step with zero distance and zero radius ends after the
// square root. in_ch.ready is high only while the sequencer is idle.
// A finished result sits in the output register; the next word can be
// accepted while it waits, but its own result holds in the last state until
// the receiver takes the earlier one. Configuration writes go to speed and
// radius and must only be issued while the block is idle. Reset clears the
// route, the position and the flags, and restores the default speed and
// radius; the route table itself is not cleared, since only written entries
// are ever read.
module waypoint_route_follower_core (
  input  logic                     clk,
  input  logic                     rst_n,
  wrf_in_if.sink                   in_ch,
  wrf_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [wrf_pkg::CFG_W-1:0] cfg_wdata
);
  import wrf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_SQX   = 4'd3;
  localparam logic [3:0] S_SQY   = 4'd4;
  localparam logic [3:0] S_RSQ   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DLOAD = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_MOVE  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam int DW  = POS_W + 1;      // offset and magnitude width
  localparam int SQW = 2 * DW;         // squared distance width
  localparam int MW  = DW + 32;        // multiplier product width
  localparam int RW  = MW - 16;        // dividend width
  localparam int QW  = 16;             // quotient width
  localparam logic signed [POS_W+1:0] POS_MAX = 26'sd8388607;
  localparam logic signed [POS_W+1:0] POS_MIN = -26'sd8388608;

  logic [3:0]              state_r, state_nxt;
  in_word_t                word_r;
  logic [CFG_W-1:0]        speed_r, radius_r;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        nw_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic                    done_r, rej_r;
  logic signed [DW-1:0]    dx_r, dy_r;
  logic [MW-1:0]           mul_r;
  logic [SQW-1:0]          acc_r;
  logic [SQW-1:0]          sqn_r, sqres_r, sqbit_r;
  logic [31:0]             scale_r;
  logic [RW-1:0]           rem_r;
  logic [QW-1:0]           quo_r, qx_r;
  logic [4:0]              cnt_r;
  logic                    axis_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic                    ram_we;
  logic [WP_W-1:0]         ram_rdata;
  logic [DW-1:0]           mag_x, mag_y;
  logic [DW-1:0]           mul_a;
  logic [31:0]             mul_b;
  logic [SQW-1:0]          sq_try;
  logic [DW-1:0]           sq_root;
  logic [RW-1:0]           div_try;
  logic                    div_ge;
  logic [QW-1:0]           quo_fin;
  logic [LEN_W-1:0]        nw_inc;
  logic signed [POS_W+1:0] sum_x, sum_y;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign ram_we = (state_r == S_EXEC) && (word_r.mode == MODE_APPEND) &&
                  (len_r < LEN_W'(ROUTE_DEPTH));

  wrf_ram #(.W(WP_W), .D(ROUTE_DEPTH)) u_route (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata ({word_r.coord_x, word_r.coord_y}),
    .raddr (nw_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign mag_x = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign mag_y = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  // The shared multiplier takes its operands from the current state.
  always_comb begin
    mul_a = mag_x;
    mul_b = 32'(mag_x);
    case (state_r)
      S_SQX: begin
        mul_a = mag_x;
        mul_b = 32'(mag_x);
      end
      S_SQY: begin
        mul_a = mag_y;
        mul_b = 32'(mag_y);
      end
      S_RSQ: begin
        mul_a = DW'(radius_r);
        mul_b = 32'(radius_r);
      end
      S_CMP: begin
        mul_a = DW'(speed_r);
        mul_b = 32'(word_r.step_time);
      end
      S_MUL: begin
        mul_a = axis_r ? mag_y : mag_x;
        mul_b = scale_r;
      end
      default: begin
        mul_a = mag_x;
        mul_b = 32'(mag_x);
      end
    endcase
  end

  assign sq_try  = sqres_r + sqbit_r;
  assign sq_root = sqres_r[DW-1:0];
  assign div_try = RW'(sq_root) << cnt_r[3:0];
  assign div_ge  = (rem_r >= div_try);
  assign quo_fin = {quo_r[QW-2:0], div_ge};
  assign nw_inc  = nw_r + LEN_W'(1);

  assign sum_x = (POS_W+2)'(px_r) + (dx_r[DW-1] ? -$signed({10'b0, qx_r}) :
                                                   $signed({10'b0, qx_r}));
  assign sum_y = (POS_W+2)'(py_r) + (dy_r[DW-1] ? -$signed({10'b0, quo_r}) :
                                                   $signed({10'b0, quo_r}));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (word_r.mode == MODE_STEP && len_r != '0 && nw_r < len_r) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIFF:  state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_RSQ;
      S_RSQ:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (acc_r < SQW'(mul_r[31:0])) ? S_OUT : S_SQRT;
      S_SQRT:  if (cnt_r == '0) state_nxt = S_MUL;
      S_MUL:   state_nxt = (sq_root == '0) ? S_OUT : S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == '0) state_nxt = axis_r ? S_MOVE : S_MUL;
      end
      S_MOVE:  state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      speed_r     <= SPEED_RESET;
      radius_r    <= RADIUS_RESET;
      len_r       <= '0;
      nw_r        <= '0;
      px_r        <= '0;
      py_r        <= '0;
      done_r      <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SPEED) speed_r <= cfg_wdata;
        else radius_r <= cfg_wdata;
      end
      // A new result replaces the one being taken in the same cycle.
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) word_r <= in_ch.data;
        end
        S_EXEC: begin
          done_r <= 1'b0;
          rej_r  <= 1'b0;
          axis_r <= 1'b0;
          if (word_r.mode == MODE_APPEND) begin
            if (len_r < LEN_W'(ROUTE_DEPTH)) len_r <= len_r + LEN_W'(1);
            else rej_r <= 1'b1;
          end else if (word_r.mode == MODE_SETPOS) begin
            px_r <= word_r.coord_x;
            py_r <= word_r.coord_y;
          end
        end
        S_DIFF: begin
          dx_r <= DW'($signed(ram_rdata[WP_W-1:POS_W])) - DW'(px_r);
          dy_r <= DW'($signed(ram_rdata[POS_W-1:0])) - DW'(py_r);
        end
        S_SQX: mul_r <= mul_a * mul_b;
        S_SQY: begin
          acc_r <= mul_r[SQW-1:0];
          mul_r <= mul_a * mul_b;
        end
        S_RSQ: begin
          acc_r <= acc_r + mul_r[SQW-1:0];
          mul_r <= mul_a * mul_b;
        end
        S_CMP: begin
          if (acc_r < SQW'(mul_r[31:0])) begin
            // Waypoint reached; finishing the last one clears the route.
            if (nw_inc == len_r) begin
              len_r  <= '0;
              nw_r   <= '0;
              done_r <= 1'b1;
            end else begin
              nw_r <= nw_inc;
            end
          end
          mul_r   <= mul_a * mul_b;
          sqn_r   <= acc_r;
          sqres_r <= '0;
          sqbit_r <= SQW'(1) << (SQW - 2);
          cnt_r   <= 5'(DW - 1);
        end
        S_SQRT: begin
          scale_r <= mul_r[31:0];
          if (sqn_r >= sq_try) begin
            sqn_r   <= sqn_r - sq_try;
            sqres_r <= (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_r <= sqres_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
          cnt_r   <= cnt_r - 5'd1;
        end
        S_MUL: mul_r <= mul_a * mul_b;
        S_DLOAD: begin
          rem_r <= mul_r[MW-1:16];
          quo_r <= '0;
          cnt_r <= 5'(QW - 1);
        end
        S_DIV: begin
          if (div_ge) rem_r <= rem_r - div_try;
          quo_r <= quo_fin;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0 && !axis_r) begin
            qx_r   <= quo_fin;
            axis_r <= 1'b1;
          end
        end
        S_MOVE: begin
          px_r <= (sum_x > POS_MAX) ? POS_MAX[POS_W-1:0] :
                  (sum_x < POS_MIN) ? POS_MIN[POS_W-1:0] : sum_x[POS_W-1:0];
          py_r <= (sum_y > POS_MAX) ? POS_MAX[POS_W-1:0] :
                  (sum_y < POS_MIN) ? POS_MIN[POS_W-1:0] : sum_y[POS_W-1:0];
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r.pos_x        <= px_r;
            out_r.pos_y        <= py_r;
            out_r.target_index <= TIDX_W'(nw_r);
            out_r.route_done   <= done_r;
            out_r.rejected     <= rej_r;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
